// File: sv/rzs_pkg.sv
// ----------------------------------------------------------------------------
// rzs_pkg
// Types, codes and helpers shared by the robust z-score unit.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int FLOOR_W  = 17;
  localparam int PCT_W    = 35;
  localparam int DVS_W    = 36;
  localparam int NUM_W    = 52;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_EVAL   = 2'd2;

  localparam logic [31:0] Z_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Z_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [31:0]  sample_value;
  } rzs_in_t;

  typedef struct packed {
    logic signed [31:0]  zscore;
    logic                saturated;
    logic                history_empty;
  } rzs_out_t;

  typedef struct packed {
    logic clear;
    logic append;
  } hist_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_KEYW,
    ST_SCAN,
    ST_DRAIN,
    ST_RANK,
    ST_PCT,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_OUT
  } rzs_state_t;

  // Percentile in quarter units: a*(4-f) + b*f
  function automatic logic signed [PCT_W-1:0] pct4(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic [1:0] f);
    logic signed [PCT_W-1:0] ea;
    logic signed [PCT_W-1:0] eb;
    logic signed [PCT_W-1:0] r;
    ea = PCT_W'(a);
    eb = PCT_W'(b);
    case (f)
      2'd0:    r = ea <<< 2;
      2'd1:    r = (ea <<< 1) + ea + eb;
      2'd2:    r = (ea <<< 1) + (eb <<< 1);
      default: r = ea + (eb <<< 1) + eb;
    endcase
    return r;
  endfunction

endpackage

// File: sv/rzs_hist.sv
// ----------------------------------------------------------------------------
// rzs_hist
// History window: sample memory, fill count and oldest pointer.
// ----------------------------------------------------------------------------
module rzs_hist #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rzs_pkg::hist_cmd_t                  cmd,
  input  logic signed [31:0]                  wdata,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]    raddr,
  output logic signed [31:0]                  rdata,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]  count
);
  import rzs_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  logic signed [31:0] mem [HISTORY_DEPTH];
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      waddr;
  logic [CW:0]        sum;
  logic               full;

  assign full = (count_r == CW'(HISTORY_DEPTH));
  assign sum  = (CW+1)'(ptr_r) + (CW+1)'(count_r);

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    if (sum >= (CW+1)'(HISTORY_DEPTH)) begin
      waddr = AW'(sum - (CW+1)'(HISTORY_DEPTH));
    end else begin
      waddr = AW'(sum);
    end
    if (full) begin
      waddr = ptr_r;
    end
    if (cmd.clear) begin
      count_nxt = '0;
      ptr_nxt   = '0;
    end else if (cmd.append) begin
      if (full) begin
        ptr_nxt = (ptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign count = count_r;

endmodule

// File: sv/rzs_div.sv
// ----------------------------------------------------------------------------
// rzs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rzs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rzs_pkg::NUM_W-1:0]   dividend,
  input  logic [rzs_pkg::DVS_W-1:0]   divisor,
  output logic [rzs_pkg::NUM_W-1:0]   quotient,
  output logic                        done
);
  import rzs_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             qbit;

  assign rem_sh = {rem_r[DVS_W-1:0], dvd_r[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? rem_sh - {1'b0, dvs_r} : rem_sh;
      dvd_r <= {dvd_r[NUM_W-2:0], qbit};
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

// File: sv/robust_zscore_median_iqr_unit.sv
// ----------------------------------------------------------------------------
// robust_zscore_median_iqr_unit
// Robust z-score of a value against a sliding window of Q16.16 samples.
// ----------------------------------------------------------------------------
// Clear and append transactions leave the unit in idle. An evaluate transaction
// ranks each sample in the window with one shared comparator that sweeps the
// window memory through its single read port, then a one-bit-per-cycle divider
// forms the 52-bit quotient. An evaluate on an empty window skips the ranking
// and the divide and goes straight to the output state.
// in_stall stays high for the whole evaluation; one result is returned per
// evaluate transaction, none for the others.
module robust_zscore_median_iqr_unit #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rzs_pkg::rzs_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rzs_pkg::rzs_out_t     out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [16:0]           cfg_data
);
  import rzs_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = CW + 2;

  rzs_state_t state_r, state_nxt;

  logic [FLOOR_W-1:0]     floor_r;
  hist_cmd_t              cmd;
  logic signed [31:0]     rd;
  logic [CW-1:0]          count;
  logic [AW-1:0]          raddr;
  logic                   in_acc;
  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       quo;

  logic [CW-1:0]          n_m1_r, i_r, j_r, rank_r;
  logic [AW-1:0]          cmp_j_r;
  logic                   cmp_v_r;
  logic signed [31:0]     key_r, cur_r;
  logic [CW-1:0]          lo_r [3];
  logic [CW-1:0]          hi_r [3];
  logic [1:0]             f_r  [3];
  logic signed [31:0]     tlo_r [3];
  logic signed [31:0]     thi_r [3];
  logic signed [PCT_W-1:0] q1_r, med_r, q3_r;
  logic [DVS_W-1:0]       dvs_r;
  logic [NUM_W-1:0]       num_r;
  logic                   neg_r;
  rzs_out_t               res_r;
  logic                   out_valid_r;
  rzs_out_t               out_r;
  logic                   out_free;

  logic [PW-1:0]          pos [3];
  logic signed [DVS_W-1:0] iqr;
  logic [DVS_W-1:0]       fl4;
  logic signed [DVS_W-1:0] diff;
  logic [DVS_W-1:0]       mag;
  logic                   sat_pos, sat_neg;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= FLOOR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      floor_r <= cfg_data;
    end
  end

  assign cmd.clear  = in_acc && (in_data.kind == KIND_CLEAR);
  assign cmd.append = in_acc && (in_data.kind == KIND_APPEND);

  rzs_hist #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .wdata (in_data.sample_value),
    .raddr (raddr),
    .rdata (rd),
    .count (count)
  );

  rzs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (dvs_r),
    .quotient (quo),
    .done     (div_done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.kind == KIND_EVAL) begin
          state_nxt = (count == '0) ? ST_OUT : ST_KEY;
        end
      end
      ST_KEY:   state_nxt = ST_KEYW;
      ST_KEYW:  state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = (j_r == n_m1_r) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_nxt = ST_RANK;
      ST_RANK:  state_nxt = (i_r == n_m1_r) ? ST_PCT : ST_KEY;
      ST_PCT:   state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = div_done ? ST_OUT : ST_DIV;
      ST_OUT:   state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    raddr     = j_r[AW-1:0];
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_KEY:   raddr = i_r[AW-1:0];
      ST_START: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= (state_r == ST_SCAN);
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = PW'(n_m1_r) * PW'(k + 1);
    end
    iqr     = DVS_W'(q3_r) - DVS_W'(q1_r);
    fl4     = {(DVS_W-FLOOR_W-2)'(0), (floor_r == '0) ? FLOOR_W'(1) : floor_r, 2'b00};
    diff    = (DVS_W'(cur_r) <<< 2) - DVS_W'(med_r);
    mag     = diff[DVS_W-1] ? DVS_W'(-diff) : DVS_W'(diff);
    sat_pos = |quo[NUM_W-1:31];
    sat_neg = (|quo[NUM_W-1:32]) || (quo[31] && (|quo[30:0]));
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      cur_r  <= in_data.sample_value;
      n_m1_r <= count - 1'b1;
      i_r    <= '0;
      res_r  <= '{zscore: '0, saturated: 1'b0, history_empty: 1'b1};
    end
    if (state_r == ST_KEY) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= CW'(pos[k] >> 2);
        f_r[k]  <= pos[k][1:0];
        hi_r[k] <= (pos[k][1:0] != 2'd0) ? CW'(pos[k] >> 2) + 1'b1 : CW'(pos[k] >> 2);
      end
    end
    if (state_r == ST_KEYW) begin
      key_r  <= rd;
      j_r    <= '0;
      rank_r <= '0;
    end
    if (state_r == ST_SCAN) begin
      j_r     <= j_r + 1'b1;
      cmp_j_r <= j_r[AW-1:0];
    end
    if (cmp_v_r && ((rd < key_r) || (rd == key_r && cmp_j_r < i_r[AW-1:0]))) begin
      rank_r <= rank_r + 1'b1;
    end
    if (state_r == ST_RANK) begin
      i_r <= i_r + 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (rank_r == lo_r[k]) tlo_r[k] <= key_r;
        if (rank_r == hi_r[k]) thi_r[k] <= key_r;
      end
    end
    if (state_r == ST_PCT) begin
      q1_r  <= pct4(tlo_r[0], thi_r[0], f_r[0]);
      med_r <= pct4(tlo_r[1], thi_r[1], f_r[1]);
      q3_r  <= pct4(tlo_r[2], thi_r[2], f_r[2]);
    end
    if (state_r == ST_PREP) begin
      dvs_r <= ($signed(iqr) < $signed(fl4)) ? fl4 : DVS_W'(iqr);
      num_r <= {mag, 16'h0000};
      neg_r <= diff[DVS_W-1];
    end
    if (state_r == ST_DIV && div_done) begin
      res_r.history_empty <= 1'b0;
      if (neg_r) begin
        res_r.saturated <= sat_neg;
        res_r.zscore    <= sat_neg ? Z_MIN : -quo[31:0];
      end else begin
        res_r.saturated <= sat_pos;
        res_r.zscore    <= sat_pos ? Z_MAX : quo[31:0];
      end
    end
    if (state_r == ST_OUT && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/rzs_checker.sv
// ----------------------------------------------------------------------------
// rzs_checker
// Port-level checks for the robust z-score unit, bound to the top level.
// ----------------------------------------------------------------------------
module rzs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input rzs_pkg::rzs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input rzs_pkg::rzs_out_t out_data
);
  import rzs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.history_empty |-> out_data.zscore == 0 && !out_data.saturated)
    else $error("empty window result not zero");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.zscore == Z_MAX || out_data.zscore == Z_MIN))
    else $error("saturated result not clipped");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_EVAL |=> in_stall)
    else $error("evaluate transaction did not hold input");

endmodule

bind robust_zscore_median_iqr_unit rzs_checker u_rzs_checker (.*);

// File: verif/tb_robust_zscore_median_iqr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_robust_zscore_median_iqr_unit
// Checks the robust z-score unit against a behavioral window model: a
// directed table, then random clear/append/evaluate/unused traffic under several
// floor settings and idle/stall patterns, scored result by result.
// ----------------------------------------------------------------------------
module tb_robust_zscore_median_iqr_unit;
  import rzs_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] value;
    bit                 typed;
    rzs_out_t           want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rzs_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rzs_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;

  logic signed [31:0] window_mem [DEPTH];
  int unsigned        window_count;
  int unsigned        window_head;
  logic [16:0]        floor_reg;

  rzs_out_t pending_scores [$];
  int       fail_count = 0;
  int       idle_mode = 0;

  robust_zscore_median_iqr_unit #(.HISTORY_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint quartile4(input logic signed [31:0] s [DEPTH],
                                       input int unsigned n, input int unsigned qu);
    int unsigned pos, lo, hi, f;
    pos = qu * (n - 1);
    lo = pos >> 2;
    f = pos & 3;
    hi = (f != 0) ? lo + 1 : lo;
    if (hi >= n) hi = n - 1;
    return longint'(s[lo]) * (4 - f) + longint'(s[hi]) * f;
  endfunction

  function automatic rzs_out_t score_of(input logic signed [31:0] cur);
    logic signed [31:0] s [DEPTH];
    logic signed [31:0] key;
    int unsigned n, i, j;
    longint med4, iqr4, fl4, num, q;
    rzs_out_t r;
    r = '0;
    if (window_count == 0) begin
      r.history_empty = 1'b1;
      return r;
    end
    n = window_count;
    for (i = 0; i < DEPTH; i++) s[i] = window_mem[i];
    for (i = 1; i < n; i++) begin
      key = s[i];
      j = i;
      while (j > 0 && s[j-1] > key) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = key;
    end
    med4 = quartile4(s, n, 2);
    iqr4 = quartile4(s, n, 3) - quartile4(s, n, 1);
    fl4 = longint'((floor_reg == 0) ? 17'd1 : floor_reg) * 4;
    if (iqr4 < fl4) iqr4 = fl4;
    num = (longint'(cur) * 4 - med4) * 65536;
    q = num / iqr4;
    if (q > longint'(32'sh7FFF_FFFF)) begin
      r.zscore = Z_MAX;
      r.saturated = 1'b1;
    end else if (q < -longint'(64'h8000_0000)) begin
      r.zscore = Z_MIN;
      r.saturated = 1'b1;
    end else begin
      r.zscore = q[31:0];
    end
    return r;
  endfunction

  task automatic window_update(input rzs_in_t it);
    case (it.kind)
      KIND_CLEAR: begin
        window_count = 0;
        window_head = 0;
      end
      KIND_APPEND: begin
        if (window_count < DEPTH) begin
          window_mem[(window_head + window_count) % DEPTH] = it.sample_value;
          window_count++;
        end else begin
          window_mem[window_head] = it.sample_value;
          window_head = (window_head + 1) % DEPTH;
        end
      end
      KIND_EVAL: pending_scores.push_back(score_of(it.sample_value));
      default: ;
    endcase
  endtask

  task automatic sender_gap();
    int unsigned pct;
    pct = (idle_mode == 1) ? 78 : (idle_mode == 3) ? 30 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic send_item(input rzs_in_t it, input bit typed, input rzs_out_t want);
    sender_gap();
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) begin
      if (it.kind == KIND_EVAL) pending_scores.push_back(want);
    end else begin
      window_update(it);
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_floor(input logic [16:0] value);
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (450) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    floor_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $signed($urandom_range(2097152)) - 32'sd1048576;
      default: return $signed($urandom_range(655360)) - 32'sd327680;
    endcase
  endfunction

  always @(negedge clk) begin
    if (idle_mode == 2) out_stall <= ($urandom_range(99) < 78);
    else if (idle_mode == 3) out_stall <= ($urandom_range(99) < 30);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    rzs_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result transaction zscore=%0d", out_data.zscore);
        fail_count++;
      end else begin
        w = pending_scores.pop_front();
        if (out_data.zscore !== w.zscore) begin
          $error("zscore: expected %0d actual %0d", w.zscore, out_data.zscore);
          fail_count++;
        end
        if (out_data.saturated !== w.saturated) begin
          $error("saturated: expected %0b actual %0b", w.saturated, out_data.saturated);
          fail_count++;
        end
        if (out_data.history_empty !== w.history_empty) begin
          $error("history_empty: expected %0b actual %0b",
                 w.history_empty, out_data.history_empty);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    rzs_in_t it;
    rzs_out_t none;
    logic [16:0] floors [4];
    int unsigned k, ph, sel;

    none = '0;
    window_count = 0;
    window_head = 0;
    floor_reg = 17'd1;
    for (k = 0; k < DEPTH; k++) window_mem[k] = '0;

    rows.push_back('{KIND_EVAL, 32'sd0, 1, '{32'sd0, 1'b0, 1'b1}});
    rows.push_back('{KIND_APPEND, 32'sd0, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh7FFF_FFFF, 1, '{Z_MAX, 1'b1, 1'b0}});
    rows.push_back('{KIND_EVAL, 32'sh8000_0000, 1, '{Z_MIN, 1'b1, 1'b0}});
    rows.push_back('{KIND_EVAL, 32'sd0, 1, '{32'sd0, 1'b0, 1'b0}});
    rows.push_back('{KIND_UNUSED, 32'sh7FFF_FFFF, 0, none});
    rows.push_back('{KIND_APPEND, 32'sh7FFF_FFFF, 0, none});
    rows.push_back('{KIND_APPEND, 32'sh8000_0000, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh7FFF_FFFF, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh8000_0000, 0, none});
    rows.push_back('{KIND_APPEND, 32'sh0001_0000, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh0002_8000, 0, none});
    rows.push_back('{KIND_CLEAR, 32'sh7FFF_FFFF, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh1234_5678, 1, '{32'sd0, 1'b0, 1'b1}});
    rows.push_back('{KIND_APPEND, -32'sh0003_0000, 0, none});
    rows.push_back('{KIND_APPEND, 32'sh0005_0000, 0, none});
    rows.push_back('{KIND_APPEND, 32'sh0000_4000, 0, none});
    rows.push_back('{KIND_EVAL, 32'sh0001_0000, 0, none});
    rows.push_back('{KIND_UNUSED, 32'sd0, 0, none});
    rows.push_back('{KIND_EVAL, -32'sh0001_0000, 0, none});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[k]) begin
      row = rows[k];
      it.kind = row.kind;
      it.sample_value = row.value;
      send_item(it, row.typed, row.want);
    end

    floors = '{17'd65536, 17'd0, 17'd1, 17'd0};
    floors[3] = 17'($urandom_range(65536, 1));
    for (ph = 0; ph < 4; ph++) begin
      write_floor(floors[ph]);
      idle_mode = ph;
      for (k = 0; k < 225; k++) begin
        sel = $urandom_range(99);
        if (sel < 4) it.kind = KIND_CLEAR;
        else if (sel < 8) it.kind = KIND_UNUSED;
        else if (sel < 62) it.kind = KIND_APPEND;
        else it.kind = KIND_EVAL;
        it.sample_value = rand_value();
        send_item(it, 1'b0, none);
      end
    end
    idle_mode = 0;

    while (pending_scores.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (fail_count == 0 && pending_scores.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rzs_pkg.sv
sv/rzs_hist.sv
sv/rzs_div.sv
sv/robust_zscore_median_iqr_unit.sv
sv/rzs_checker.sv
verif/tb_robust_zscore_median_iqr_unit.sv
